/* sv/assert_macros.svh */
// concurrent assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define TIAF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define TIAF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define TIAF_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define TIAF_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* sv/tiaf_pkg.sv */
package tiaf_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 24;
  localparam int COEF_FRAC_BITS_DEF = 28;
  localparam int HISTORY_DEPTH_DEF  = 4;

  localparam int COEF_W    = 32;
  localparam int MAX_TAPS  = 4;
  localparam int NUM_AXES  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_TAP1 = 3'd0,
    REG_NUM_TAP2 = 3'd1,
    REG_DEN_TAP1 = 3'd2,
    REG_DEN_TAP2 = 3'd3,
    REG_DEN_TAP3 = 3'd4,
    REG_DEN_TAP4 = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [COEF_W-1:0]                num_tap1;
    logic [COEF_W-1:0]                num_tap2;
    logic [MAX_TAPS-1:0][COEF_W-1:0]  den_tap;
  } coef_t;

  // pipeline control shared by the lanes and the output stage
  typedef struct packed {
    logic                load;
    logic                fill;
    logic                commit;
    logic                advance;
    logic [MAX_TAPS-1:0] admit;
  } ctrl_t;

endpackage

/* sv/tiaf_lane.sv */
module tiaf_lane #(
  parameter int SAMPLE_WIDTH   = tiaf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = tiaf_pkg::COEF_FRAC_BITS_DEF,
  parameter int HISTORY_DEPTH  = tiaf_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                           clk,
  input  tiaf_pkg::ctrl_t                ctrl,
  input  tiaf_pkg::coef_t                coef,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic signed [SAMPLE_WIDTH-1:0] y_next
);

  localparam int PROD_W = tiaf_pkg::COEF_W + SAMPLE_WIDTH;
  localparam int ACC_W  = PROD_W + 5;

  logic signed [SAMPLE_WIDTH-1:0] xh [HISTORY_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] yh [HISTORY_DEPTH];
  logic signed [ACC_W-1:0]        ff_term [HISTORY_DEPTH];
  logic signed [ACC_W-1:0]        fb_term [HISTORY_DEPTH];
  logic signed [ACC_W-1:0]        partial;
  logic signed [ACC_W-1:0]        partial_next;
  logic                           admit1;
  logic signed [PROD_W-1:0]       fb1_prod;
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        shifted;
  logic                           in_range;

  // feedforward taps and feedback taps two and up
  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_tap
    if (i == tiaf_pkg::MAX_TAPS - 1) begin : g_ff_unit
      assign ff_term[i] = ACC_W'(xh[i]) <<< COEF_FRAC_BITS;
    end else begin : g_ff_mul
      logic signed [tiaf_pkg::COEF_W-1:0] b;
      logic signed [PROD_W-1:0]           p;
      assign b = (i == 1) ? $signed(coef.num_tap2) : $signed(coef.num_tap1);
      assign p = b * xh[i];
      assign ff_term[i] = ACC_W'(p);
    end

    if (i == 0) begin : g_fb_none
      assign fb_term[i] = '0;
    end else begin : g_fb_mul
      logic signed [SAMPLE_WIDTH-1:0] ytap;
      logic signed [PROD_W-1:0]       p;
      // newest output still in flight when stage one is full
      assign ytap = ctrl.fill ? yh[i-1] : yh[i];
      assign p = $signed(coef.den_tap[i]) * ytap;
      assign fb_term[i] = ACC_W'(p);
    end
  end

  always_comb begin
    partial_next = ACC_W'(sample) <<< COEF_FRAC_BITS;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      if (ctrl.admit[k]) begin
        partial_next = partial_next + ff_term[k] - fb_term[k];
      end
    end
  end

  // stage two: newest feedback tap, shift and saturate
  assign fb1_prod = $signed(coef.den_tap[0]) * yh[0];
  assign acc      = partial - (admit1 ? ACC_W'(fb1_prod) : ACC_W'(0));
  assign shifted  = acc >>> COEF_FRAC_BITS;
  assign in_range = (&shifted[ACC_W-1:SAMPLE_WIDTH-1]) |
                    ~(|shifted[ACC_W-1:SAMPLE_WIDTH-1]);

  always_comb begin
    if (in_range) begin
      y_next = shifted[SAMPLE_WIDTH-1:0];
    end else if (shifted[ACC_W-1]) begin
      y_next = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      y_next = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      partial <= partial_next;
      admit1  <= ctrl.admit[0];
      xh[0]   <= sample;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        xh[i] <= xh[i-1];
      end
    end
    if (ctrl.commit) begin
      yh[0] <= y_next;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        yh[i] <= yh[i-1];
      end
    end
  end

endmodule

/* sv/tiaf_merge.sv */
module tiaf_merge #(
  parameter int SAMPLE_WIDTH = tiaf_pkg::SAMPLE_WIDTH_DEF,
  parameter int TDATA_W      = ((tiaf_pkg::NUM_AXES * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  tiaf_pkg::ctrl_t                                     ctrl,
  input  logic [tiaf_pkg::NUM_AXES-1:0][SAMPLE_WIDTH-1:0]     lane_y,
  output logic                                                m_axis_tvalid,
  output logic [TDATA_W-1:0]                                  m_axis_tdata
);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctrl.advance) begin
      m_axis_tvalid <= ctrl.fill;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      m_axis_tdata <= TDATA_W'(lane_y);
    end
  end

endmodule

/* sv/three_axis_iir_notch_filter.sv */
// three-axis fourth-order iir notch filter
// input stream: s_axis_tdata carries x, y and z samples, s_axis_tuser the
// restart flag; one transaction per three-axis sample
// output stream: m_axis_tdata carries the three filtered samples
// configuration: cfg_index selects num_tap1, num_tap2, den_tap1..den_tap4
// (indexes 0 to 5, others ignored), cfg_data is the signed q4.28 value;
// cfg_ready is always high, writes belong to idle periods
// pipeline: an accepted sample is registered in the first stage, and its
// result in the output register once the pipeline advances; the first register
// stage holds the feedforward and older feedback products, the second adds the
// newest feedback product, shifts and saturates
// throughput: one sample per cycle unless the output stalls, set by the
// feedback path through the second stage; the three axes run in parallel lanes
// reset: coefficients go to zero, the pipeline empties and the warm-up count
// clears, so history taps are admitted again one per sample
// stall: while a result waits with m_axis_tready low the whole pipeline
// holds and s_axis_tready drops
`include "assert_macros.svh"

module three_axis_iir_notch_filter #(
  parameter int SAMPLE_WIDTH   = tiaf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = tiaf_pkg::COEF_FRAC_BITS_DEF,
  parameter int HISTORY_DEPTH  = tiaf_pkg::HISTORY_DEPTH_DEF,
  localparam int TDATA_W = ((tiaf_pkg::NUM_AXES * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [TDATA_W-1:0]                s_axis_tdata,  // x_sample, y_sample, z_sample
  input  logic                              s_axis_tuser,  // restart
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [TDATA_W-1:0]                m_axis_tdata,  // x_filtered, y_filtered, z_filtered
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tiaf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tiaf_pkg::COEF_W-1:0]       cfg_data
);

  localparam logic [tiaf_pkg::CNT_W-1:0] CNT_MAX = tiaf_pkg::CNT_W'(HISTORY_DEPTH);

  tiaf_pkg::coef_t                                    coef;
  tiaf_pkg::ctrl_t                                    ctrl;
  logic                                               advance;
  logic                                               stage1_valid;
  logic [tiaf_pkg::CNT_W-1:0]                         warm_cnt;
  logic [tiaf_pkg::CNT_W-1:0]                         warm_cnt_next;
  logic [tiaf_pkg::CNT_W-1:0]                         cnt_base;
  logic [tiaf_pkg::MAX_TAPS-1:0]                      admit;
  logic [tiaf_pkg::NUM_AXES-1:0][SAMPLE_WIDTH-1:0]    lane_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg_valid) begin
      case (tiaf_pkg::cfg_reg_t'(cfg_index))
        tiaf_pkg::REG_NUM_TAP1: coef.num_tap1   <= cfg_data;
        tiaf_pkg::REG_NUM_TAP2: coef.num_tap2   <= cfg_data;
        tiaf_pkg::REG_DEN_TAP1: coef.den_tap[0] <= cfg_data;
        tiaf_pkg::REG_DEN_TAP2: coef.den_tap[1] <= cfg_data;
        tiaf_pkg::REG_DEN_TAP3: coef.den_tap[2] <= cfg_data;
        tiaf_pkg::REG_DEN_TAP4: coef.den_tap[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline moves whenever the output register is free or being drained
  assign advance       = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = advance;

  // warm-up count, restart clears it before the current sample
  assign cnt_base = s_axis_tuser ? '0 : warm_cnt;
  assign warm_cnt_next = (cnt_base < CNT_MAX) ? cnt_base + 1'b1 : cnt_base;

  always_comb begin
    for (int k = 0; k < tiaf_pkg::MAX_TAPS; k++) begin
      admit[k] = cnt_base > tiaf_pkg::CNT_W'(k);
    end
  end

  assign ctrl.load    = s_axis_tvalid & advance;
  assign ctrl.fill    = stage1_valid;
  assign ctrl.commit  = stage1_valid & advance;
  assign ctrl.advance = advance;
  assign ctrl.admit   = admit;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1_valid <= 1'b0;
      warm_cnt     <= '0;
    end else begin
      if (advance) begin
        stage1_valid <= s_axis_tvalid;
      end
      if (ctrl.load) begin
        warm_cnt <= warm_cnt_next;
      end
    end
  end

  for (genvar a = 0; a < tiaf_pkg::NUM_AXES; a++) begin : g_lane
    tiaf_lane #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .HISTORY_DEPTH  (HISTORY_DEPTH)
    ) u_lane (
      .clk    (clk),
      .ctrl   (ctrl),
      .coef   (coef),
      .sample ($signed(s_axis_tdata[a*SAMPLE_WIDTH +: SAMPLE_WIDTH])),
      .y_next (lane_y[a])
    );
  end

  tiaf_merge #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .TDATA_W      (TDATA_W)
  ) u_merge (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .lane_y        (lane_y),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata)
  );

  `TIAF_ASSERT_SAME(a_cnt_bound, clk, rst, 1'b1, warm_cnt <= CNT_MAX)
  `TIAF_ASSERT_SAME(a_stall_blocks, clk, rst, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `TIAF_ASSERT_NEXT(a_stage1_to_out, clk, rst, stage1_valid && advance, m_axis_tvalid)
  `TIAF_ASSERT_NEXT(a_restart_cnt, clk, rst, ctrl.load && s_axis_tuser, warm_cnt == 3'd1)
  `TIAF_ASSERT_NEXT(a_stall_holds, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int SW = tiaf_pkg::SAMPLE_WIDTH_DEF;
  localparam int FRAC = tiaf_pkg::COEF_FRAC_BITS_DEF;
  localparam int DEPTH = tiaf_pkg::HISTORY_DEPTH_DEF;
  localparam int TDATA_W = ((tiaf_pkg::NUM_AXES * SW + 7) / 8) * 8;
  localparam int LIMIT = 400000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 116;

  localparam logic [tiaf_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [tiaf_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [tiaf_pkg::COEF_W-1:0] COEF_MAX = 32'h7fff_ffff;
  localparam logic [tiaf_pkg::COEF_W-1:0] COEF_MIN = 32'h8000_0000;
  localparam logic [tiaf_pkg::COEF_W-1:0] COEF_ONE = 32'h1000_0000;
  localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam longint OUT_MAX = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;

  typedef enum int {COEF_STABLE, COEF_RANDOM, COEF_EXTREME} coef_mode_t;

  typedef struct {
    logic restart;
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] y;
    logic signed [SW-1:0] z;
    bit wait_drain;
  } sample_t;

  typedef struct {
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] y;
    logic signed [SW-1:0] z;
  } axes_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tiaf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tiaf_pkg::COEF_W-1:0] cfg_data = '0;

  sample_t samples_q[$];
  axes_t filtered_q[$];
  sample_t cur_sample;
  longint coef_reg [6] = '{default: 0};
  logic signed [SW-1:0] in_hist [tiaf_pkg::NUM_AXES][tiaf_pkg::MAX_TAPS];
  logic signed [SW-1:0] out_hist [tiaf_pkg::NUM_AXES][tiaf_pkg::MAX_TAPS];
  int unsigned warmup;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int cycles = 0;

  three_axis_iir_notch_filter uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic axes_t filter_step(sample_t s);
    logic signed [SW-1:0] smp [tiaf_pkg::NUM_AXES];
    logic signed [SW-1:0] res [tiaf_pkg::NUM_AXES];
    longint acc;
    longint ff;
    axes_t out;
    if (s.restart) warmup = 0;
    smp[0] = s.x;
    smp[1] = s.y;
    smp[2] = s.z;
    for (int a = 0; a < tiaf_pkg::NUM_AXES; a++) begin
      acc = longint'(smp[a]) <<< FRAC;
      for (int k = 0; k < DEPTH; k++) begin
        if (warmup >= k + 1) begin
          if (k == 1) ff = coef_reg[tiaf_pkg::REG_NUM_TAP2];
          else if (k == 3) ff = longint'(1) <<< FRAC;
          else ff = coef_reg[tiaf_pkg::REG_NUM_TAP1];
          acc += ff * longint'(in_hist[a][k]);
          acc -= coef_reg[tiaf_pkg::REG_DEN_TAP1 + k] * longint'(out_hist[a][k]);
        end
      end
      acc = acc >>> FRAC;
      if (acc > OUT_MAX) acc = OUT_MAX;
      else if (acc < OUT_MIN) acc = OUT_MIN;
      res[a] = acc[SW-1:0];
      for (int k = tiaf_pkg::MAX_TAPS - 1; k > 0; k--) begin
        in_hist[a][k] = in_hist[a][k-1];
        out_hist[a][k] = out_hist[a][k-1];
      end
      in_hist[a][0] = smp[a];
      out_hist[a][0] = res[a];
    end
    if (warmup < DEPTH) warmup++;
    out.x = res[0];
    out.y = res[1];
    out.z = res[2];
    return out;
  endfunction

  function automatic void check_axis(string name, logic signed [SW-1:0] want,
                                     logic signed [SW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      warmup = 0;
      for (int a = 0; a < tiaf_pkg::NUM_AXES; a++) begin
        for (int k = 0; k < tiaf_pkg::MAX_TAPS; k++) begin
          in_hist[a][k] = '0;
          out_hist[a][k] = '0;
        end
      end
    end else begin
      if (s_axis_tvalid && s_axis_tready) filtered_q.push_back(filter_step(cur_sample));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (samples_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(samples_q[0].wait_drain && filtered_q.size() != 0)) begin
          cur_sample = samples_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {cur_sample.z, cur_sample.y, cur_sample.x};
          s_axis_tuser <= cur_sample.restart;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    axes_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected output transaction: %h", m_axis_tdata);
          errors++;
        end else begin
          want = filtered_q.pop_front();
          check_axis("x_filtered", want.x, m_axis_tdata[SW-1:0]);
          check_axis("y_filtered", want.y, m_axis_tdata[2*SW-1:SW]);
          check_axis("z_filtered", want.z, m_axis_tdata[3*SW-1:2*SW]);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("[three_axis_iir_notch_filter] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [tiaf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tiaf_pkg::COEF_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= tiaf_pkg::REG_DEN_TAP4) coef_reg[idx] = longint'($signed(val));
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [tiaf_pkg::COEF_W-1:0] val);
    for (int r = tiaf_pkg::REG_NUM_TAP1; r <= tiaf_pkg::REG_DEN_TAP4; r++) begin
      write_reg(tiaf_pkg::CFG_IDX_W'(r), val);
    end
  endtask

  task automatic push_sample(input logic restart, input logic signed [SW-1:0] x,
                             input logic signed [SW-1:0] y, input logic signed [SW-1:0] z);
    sample_t s;
    s.restart = restart;
    s.x = x;
    s.y = y;
    s.z = z;
    s.wait_drain = 1'b0;
    samples_q.push_back(s);
  endtask

  task automatic wait_idle();
    while (samples_q.size() != 0 || s_axis_tvalid || filtered_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(9))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2, 3: return SW'(int'($urandom_range(2000)) - 1000);
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic [tiaf_pkg::COEF_W-1:0] rand_coef(input coef_mode_t mode,
                                                            input bit feedback);
    case (mode)
      COEF_STABLE: begin
        // feedback taps within +-0.25 keep the loop stable
        if (feedback) return tiaf_pkg::COEF_W'(int'($urandom_range(1 << 27)) - (1 << 26));
        return tiaf_pkg::COEF_W'(int'($urandom_range(1 << 31)) - (1 << 30));
      end
      COEF_EXTREME: begin
        case ($urandom_range(3))
          0: return COEF_MAX;
          1: return COEF_MIN;
          2: return COEF_ONE;
          default: return '0;
        endcase
      end
      default: return tiaf_pkg::COEF_W'($urandom);
    endcase
  endfunction

  initial begin
    sample_t s;
    coef_mode_t mode;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset coefficients: output is x plus the sample four back once warm
    push_sample(1'b1, SMP_MAX, SMP_MIN, 0);
    push_sample(1'b0, SMP_MAX, SMP_MIN, -1);
    push_sample(1'b0, 1, -1, SMP_MAX);
    push_sample(1'b0, SMP_MIN, SMP_MAX, SMP_MIN);
    push_sample(1'b0, SMP_MAX, SMP_MIN, 0);
    push_sample(1'b0, SMP_MIN, 0, 1);
    push_sample(1'b1, SMP_MAX, SMP_MAX, SMP_MAX);
    push_sample(1'b0, 0, 0, 0);
    push_sample(1'b0, 0, 0, 0);
    push_sample(1'b0, 0, 0, 0);
    push_sample(1'b0, 5, -5, SMP_MAX);
    wait_idle();

    // writes to unused indexes must not land anywhere
    write_reg(REG_SPARE_LO, COEF_MAX);
    write_reg(REG_SPARE_HI, COEF_MIN);
    push_sample(1'b0, 100, -100, 0);
    push_sample(1'b0, 0, 0, 0);
    wait_idle();

    write_all(COEF_MAX);
    push_sample(1'b1, SMP_MAX, SMP_MIN, 1);
    push_sample(1'b0, -1, 0, SMP_MAX);
    push_sample(1'b0, 0, 1, SMP_MIN);
    push_sample(1'b0, SMP_MIN, SMP_MAX, -1);
    push_sample(1'b0, 1, -1, 0);
    wait_idle();

    write_all(COEF_MIN);
    push_sample(1'b1, SMP_MIN, SMP_MAX, -1);
    push_sample(1'b0, SMP_MAX, SMP_MIN, 1);
    push_sample(1'b0, 0, 0, 0);
    push_sample(1'b0, -1, 1, SMP_MIN);
    push_sample(1'b0, SMP_MAX, SMP_MAX, SMP_MAX);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 4)
        1: mode = COEF_RANDOM;
        3: mode = COEF_EXTREME;
        default: mode = COEF_STABLE;
      endcase
      write_reg(tiaf_pkg::REG_NUM_TAP1, rand_coef(mode, 1'b0));
      write_reg(tiaf_pkg::REG_NUM_TAP2, rand_coef(mode, 1'b0));
      write_reg(tiaf_pkg::REG_DEN_TAP1, rand_coef(mode, 1'b1));
      write_reg(tiaf_pkg::REG_DEN_TAP2, rand_coef(mode, 1'b1));
      write_reg(tiaf_pkg::REG_DEN_TAP3, rand_coef(mode, 1'b1));
      write_reg(tiaf_pkg::REG_DEN_TAP4, rand_coef(mode, 1'b1));
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 87; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 87; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        s.restart = (i == 0) || ($urandom_range(19) == 0);
        s.x = rand_sample();
        s.y = rand_sample();
        s.z = rand_sample();
        s.wait_drain = (i == 40) || ($urandom_range(149) == 0);
        samples_q.push_back(s);
      end
      wait_idle();
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[three_axis_iir_notch_filter] OK");
    end else begin
      $display("[three_axis_iir_notch_filter] ERROR");
    end
    $finish;
  end

endmodule

/* three_axis_iir_notch_filter.f */
+incdir+sv
sv/tiaf_pkg.sv
sv/tiaf_lane.sv
sv/tiaf_merge.sv
sv/three_axis_iir_notch_filter.sv
dv/tb.sv
